// ===== rtl/core/bll_pkg.sv =====
// bll_pkg: token kinds, error codes, lexer modes, result item type,
// keyword table and character class helpers for basic_like_lexer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bll_pkg;

    localparam int TOKEN_W    = 16;
    localparam int NUM_KW     = 11;
    localparam int MAX_KW_LEN = 8;

    localparam logic [4:0] K_EOF   = 5'd0;
    localparam logic [4:0] K_NL    = 5'd1;
    localparam logic [4:0] K_NUM   = 5'd2;
    localparam logic [4:0] K_IDENT = 5'd3;
    localparam logic [4:0] K_STR   = 5'd4;
    localparam logic [4:0] K_KW0   = 5'd5;
    localparam logic [4:0] K_EQ    = 5'd16;
    localparam logic [4:0] K_PLUS  = 5'd17;
    localparam logic [4:0] K_MINUS = 5'd18;
    localparam logic [4:0] K_STAR  = 5'd19;
    localparam logic [4:0] K_SLASH = 5'd20;
    localparam logic [4:0] K_EQEQ  = 5'd21;
    localparam logic [4:0] K_NOTEQ = 5'd22;
    localparam logic [4:0] K_LT    = 5'd23;
    localparam logic [4:0] K_LTEQ  = 5'd24;
    localparam logic [4:0] K_GT    = 5'd25;
    localparam logic [4:0] K_GTEQ  = 5'd26;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NUMBER   = 3'd1;
    localparam logic [2:0] ERR_BANG     = 3'd2;
    localparam logic [2:0] ERR_STR_CHAR = 3'd3;
    localparam logic [2:0] ERR_UNKNOWN  = 3'd4;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam logic [0:MAX_KW_LEN-1][7:0] KW_TEXT [NUM_KW] = '{
        {"L", "A", "B", "E", "L", 8'h00, 8'h00, 8'h00},
        {"G", "O", "T", "O", 8'h00, 8'h00, 8'h00, 8'h00},
        {"P", "R", "I", "N", "T", 8'h00, 8'h00, 8'h00},
        {"I", "N", "P", "U", "T", 8'h00, 8'h00, 8'h00},
        {"L", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        {"I", "F", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        {"T", "H", "E", "N", 8'h00, 8'h00, 8'h00, 8'h00},
        {"E", "N", "D", "I", "F", 8'h00, 8'h00, 8'h00},
        {"W", "H", "I", "L", "E", 8'h00, 8'h00, 8'h00},
        {"R", "E", "P", "E", "A", "T", 8'h00, 8'h00},
        {"E", "N", "D", "W", "H", "I", "L", "E"}
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd5, 4'd4, 4'd5, 4'd5, 4'd3, 4'd2, 4'd4, 4'd5, 4'd5, 4'd6, 4'd8
    };

    typedef enum logic [12:0] {
        M_IDLE    = 13'b0000000000001,
        M_INT     = 13'b0000000000010,
        M_DOT     = 13'b0000000000100,
        M_FRAC    = 13'b0000000001000,
        M_IDENT   = 13'b0000000010000,
        M_STR     = 13'b0000000100000,
        M_EQ      = 13'b0000001000000,
        M_GT      = 13'b0000010000000,
        M_LT      = 13'b0000100000000,
        M_BANG    = 13'b0001000000000,
        M_COMMENT = 13'b0010000000000,
        M_HALT    = 13'b0100000000000,
        M_DONE    = 13'b1000000000000
    } mode_t;

    typedef struct packed {
        logic [4:0]         kind;
        logic [TOKEN_W-1:0] start;
        logic [TOKEN_W-1:0] length;
        logic [2:0]         err;
        logic               last;
    } res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF)
            || (c == CH_CR);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/basic_like_lexer.sv =====
// basic_like_lexer: streaming lexer, one source byte per item, tokens out.
// Depends on bll_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  src     | src_valid, src_stall | ch, end_of_source
//  tok     | tok_valid, tok_stall | token_kind, token_start, token_length,
//          |                      | error_code, last
//
// An item passes an input register, then the lexing logic loads all of its
// results (0 to 3) into a three-entry result buffer that drains one per
// cycle while tok_stall is low; a new item loads only as the buffer empties.
// Reset (rst_n low, async) empties both stages and returns the lexer to idle.
// tok_stall holds the buffer; src_stall rises while the buffer cannot take
// the next item's results.
`timescale 1ns / 1ps
`default_nettype none

module basic_like_lexer #(
    parameter int POSITION_BITS = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         src_valid,
    output logic                        src_stall,
    input  wire  [7:0]                  ch,
    input  wire                         end_of_source,
    output logic                        tok_valid,
    input  wire                         tok_stall,
    output logic [4:0]                  token_kind,
    output logic [bll_pkg::TOKEN_W-1:0] token_start,
    output logic [bll_pkg::TOKEN_W-1:0] token_length,
    output logic [2:0]                  error_code,
    output logic                        last
);
    import bll_pkg::*;

    localparam logic [NUM_KW-1:0] ALL_CAND = '1;
    localparam logic [3:0] IDLEN_SAT = 4'(MAX_KW_LEN + 1);

    // input register
    logic       iv_reg;
    logic [7:0] ch_reg;
    logic       eos_reg;

    // lexer state
    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] tsr_reg, tsr_next;
    logic [NUM_KW-1:0]        cand_reg, cand_next;
    logic [3:0]               idlen_reg, idlen_next;
    logic                     prevnl_reg, prevnl_next;
    logic [TOKEN_W-1:0]       toklen_reg, toklen_next;

    // result buffer
    res_t       buf_reg [3];
    logic [1:0] cnt_reg;

    logic pop, load_ok, fire, active, end_i, do_feed;
    logic [7:0] cc;
    logic digit, alpha, alnum;
    logic close_en, idle_en;

    logic [NUM_KW-1:0]  cand_base, cand_add, match;
    logic [3:0]         len_base, idlen_add;
    logic [TOKEN_W-1:0] tl_base, toklen_add, toklen_inc;
    logic [4:0]         ident_kind;
    logic [POSITION_BITS-1:0] pos_plus;

    mode_t                    mode_f;
    logic [POSITION_BITS-1:0] tsr_f;
    logic [NUM_KW-1:0]        cand_f;
    logic [3:0]               idlen_f;
    logic [TOKEN_W-1:0]       toklen_f;

    res_t r0, r1, r2;
    logic e0, e1, e2, r1_en;
    res_t lst [3];
    logic [1:0] n;

    assign pop       = (cnt_reg != 2'd0) && !tok_stall;
    assign load_ok   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign fire      = iv_reg && load_ok;
    assign src_stall = iv_reg && !load_ok;

    assign active  = (mode_reg != M_HALT) && (mode_reg != M_DONE);
    assign end_i   = eos_reg || (ch_reg == CH_NUL);
    assign cc      = end_i ? CH_NL : ch_reg;
    assign do_feed = !end_i || !prevnl_reg;
    assign digit   = is_digit(cc);
    assign alpha   = is_alpha(cc);
    assign alnum   = digit || alpha;
    assign pos_plus = pos_reg + 1'b1;

    assign toklen_inc = (toklen_reg == '1) ? toklen_reg : toklen_reg + 1'b1;

    always_comb
    begin
        close_en = ((mode_reg == M_INT) && !digit && (cc != CH_DOT))
                || ((mode_reg == M_FRAC) && !digit)
                || ((mode_reg == M_IDENT) && !alnum)
                || (((mode_reg == M_EQ) || (mode_reg == M_GT) || (mode_reg == M_LT))
                    && (cc != CH_EQ));
        idle_en = close_en || (mode_reg == M_IDLE)
               || ((mode_reg == M_COMMENT) && (cc == CH_NL));
    end

    // one keyword-matching step, from scratch when a new identifier starts
    always_comb
    begin
        cand_base = idle_en ? ALL_CAND : cand_reg;
        len_base  = idle_en ? 4'd0 : idlen_reg;
        tl_base   = idle_en ? '0 : toklen_reg;
        for (int k = 0; k < NUM_KW; k++)
        begin
            match[k] = (KW_TEXT[k][len_base[2:0]] == cc);
        end
        if (len_base < 4'(MAX_KW_LEN))
        begin
            cand_add  = cand_base & match;
            idlen_add = len_base + 4'd1;
        end
        else
        begin
            cand_add  = '0;
            idlen_add = IDLEN_SAT;
        end
        toklen_add = (tl_base == '1) ? tl_base : tl_base + 1'b1;
    end

    always_comb
    begin
        ident_kind = K_IDENT;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (cand_reg[k] && (KW_LEN[k] == idlen_reg))
            begin
                ident_kind = K_KW0 + 5'(k);
            end
        end
    end

    // token closed by this byte
    always_comb
    begin
        r0.start  = 16'(tsr_reg);
        r0.err    = ERR_NONE;
        r0.length = toklen_reg;
        r0.kind   = K_NUM;
        r0.last   = 1'b0;
        unique case (mode_reg)
            M_IDENT: r0.kind = ident_kind;
            M_EQ:
            begin
                r0.kind   = K_EQ;
                r0.length = 16'd1;
            end
            M_GT:
            begin
                r0.kind   = K_GT;
                r0.length = 16'd1;
            end
            M_LT:
            begin
                r0.kind   = K_LT;
                r0.length = 16'd1;
            end
            default: r0.kind = K_NUM;
        endcase
    end

    always_comb
    begin
        mode_f   = mode_reg;
        tsr_f    = tsr_reg;
        cand_f   = cand_reg;
        idlen_f  = idlen_reg;
        toklen_f = toklen_reg;
        r1_en    = 1'b0;
        r1.kind   = K_EOF;
        r1.start  = 16'(pos_reg);
        r1.length = '0;
        r1.err    = ERR_NONE;
        r1.last   = 1'b0;

        unique case (mode_reg)
            M_INT:
            begin
                if (digit)
                begin
                    toklen_f = toklen_inc;
                end
                else if (cc == CH_DOT)
                begin
                    toklen_f = toklen_inc;
                    mode_f   = M_DOT;
                end
            end
            M_DOT:
            begin
                if (digit)
                begin
                    toklen_f = toklen_inc;
                    mode_f   = M_FRAC;
                end
                else
                begin
                    r1_en  = 1'b1;
                    r1.err = ERR_NUMBER;
                    mode_f = M_HALT;
                end
            end
            M_FRAC:
            begin
                if (digit)
                begin
                    toklen_f = toklen_inc;
                end
            end
            M_IDENT:
            begin
                if (alnum)
                begin
                    cand_f   = cand_add;
                    idlen_f  = idlen_add;
                    toklen_f = toklen_add;
                end
            end
            M_STR:
            begin
                if (cc == CH_QUOTE)
                begin
                    r1_en     = 1'b1;
                    r1.kind   = K_STR;
                    r1.start  = 16'(tsr_reg);
                    r1.length = toklen_reg;
                    mode_f    = M_IDLE;
                end
                else if ((cc == CH_CR) || (cc == CH_NL) || (cc == CH_TAB)
                         || (cc == CH_BSLASH) || (cc == CH_PCT))
                begin
                    r1_en  = 1'b1;
                    r1.err = ERR_STR_CHAR;
                    mode_f = M_HALT;
                end
                else
                begin
                    toklen_f = toklen_inc;
                end
            end
            M_EQ, M_GT, M_LT:
            begin
                if (cc == CH_EQ)
                begin
                    r1_en     = 1'b1;
                    r1.start  = 16'(tsr_reg);
                    r1.length = 16'd2;
                    r1.kind   = (mode_reg == M_EQ) ? K_EQEQ
                              : ((mode_reg == M_GT) ? K_GTEQ : K_LTEQ);
                    mode_f    = M_IDLE;
                end
            end
            M_BANG:
            begin
                if (cc == CH_EQ)
                begin
                    r1_en     = 1'b1;
                    r1.kind   = K_NOTEQ;
                    r1.start  = 16'(tsr_reg);
                    r1.length = 16'd2;
                    mode_f    = M_IDLE;
                end
                else
                begin
                    r1_en  = 1'b1;
                    r1.err = ERR_BANG;
                    mode_f = M_HALT;
                end
            end
            M_IDLE, M_COMMENT, M_HALT, M_DONE: ;
            default: ;
        endcase

        // byte seen between tokens
        if (idle_en)
        begin
            mode_f   = M_IDLE;
            tsr_f    = pos_reg;
            toklen_f = 16'd1;
            priority if (is_blank(cc))
            begin
                mode_f = M_IDLE;
            end
            else if (digit)
            begin
                mode_f = M_INT;
            end
            else if (alpha)
            begin
                mode_f   = M_IDENT;
                cand_f   = cand_add;
                idlen_f  = idlen_add;
                toklen_f = toklen_add;
            end
            else
            begin
                unique case (cc)
                    CH_HASH: mode_f = M_COMMENT;
                    CH_PLUS:
                    begin
                        r1_en     = 1'b1;
                        r1.kind   = K_PLUS;
                        r1.length = 16'd1;
                    end
                    CH_MINUS:
                    begin
                        r1_en     = 1'b1;
                        r1.kind   = K_MINUS;
                        r1.length = 16'd1;
                    end
                    CH_STAR:
                    begin
                        r1_en     = 1'b1;
                        r1.kind   = K_STAR;
                        r1.length = 16'd1;
                    end
                    CH_SLASH:
                    begin
                        r1_en     = 1'b1;
                        r1.kind   = K_SLASH;
                        r1.length = 16'd1;
                    end
                    CH_EQ:   mode_f = M_EQ;
                    CH_GT:   mode_f = M_GT;
                    CH_LT:   mode_f = M_LT;
                    CH_BANG: mode_f = M_BANG;
                    CH_QUOTE:
                    begin
                        mode_f   = M_STR;
                        tsr_f    = pos_plus;
                        toklen_f = '0;
                    end
                    CH_NL:
                    begin
                        r1_en     = 1'b1;
                        r1.kind   = K_NL;
                        r1.length = 16'd1;
                    end
                    default:
                    begin
                        r1_en  = 1'b1;
                        r1.err = ERR_UNKNOWN;
                        mode_f = M_HALT;
                    end
                endcase
            end
        end
    end

    // commit feed, then end-of-source Eof
    always_comb
    begin
        mode_next   = do_feed ? mode_f : mode_reg;
        tsr_next    = do_feed ? tsr_f : tsr_reg;
        cand_next   = do_feed ? cand_f : cand_reg;
        idlen_next  = do_feed ? idlen_f : idlen_reg;
        toklen_next = do_feed ? toklen_f : toklen_reg;
        pos_next    = do_feed ? pos_plus : pos_reg;
        prevnl_next = do_feed ? (cc == CH_NL) : prevnl_reg;

        e0 = active && do_feed && close_en;
        e1 = active && do_feed && r1_en;
        e2 = active && end_i && (mode_next != M_HALT);
        if (e2)
        begin
            mode_next = M_DONE;
        end

        r2.kind   = K_EOF;
        r2.start  = 16'(pos_next);
        r2.length = '0;
        r2.err    = ERR_NONE;
        r2.last   = 1'b1;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lst[i] = '0;
        end
        n = 2'd0;
        if (e0)
        begin
            lst[n]      = r0;
            lst[n].last = !e1 && !e2;
            n           = n + 2'd1;
        end
        if (e1)
        begin
            lst[n]      = r1;
            lst[n].last = !e2;
            n           = n + 2'd1;
        end
        if (e2)
        begin
            lst[n] = r2;
            n      = n + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (!src_stall)
        begin
            iv_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            ch_reg  <= ch;
            eos_reg <= end_of_source;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            tsr_reg    <= '0;
            cand_reg   <= ALL_CAND;
            idlen_reg  <= 4'd0;
            prevnl_reg <= 1'b0;
            toklen_reg <= '0;
        end
        else if (fire && active)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tsr_reg    <= tsr_next;
            cand_reg   <= cand_next;
            idlen_reg  <= idlen_next;
            prevnl_reg <= prevnl_next;
            toklen_reg <= toklen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (fire)
        begin
            cnt_reg <= n;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            buf_reg <= lst;
        end
        else if (pop)
        begin
            buf_reg[0] <= buf_reg[1];
            buf_reg[1] <= buf_reg[2];
        end
    end

    assign tok_valid    = (cnt_reg != 2'd0);
    assign token_kind   = buf_reg[0].kind;
    assign token_start  = buf_reg[0].start;
    assign token_length = buf_reg[0].length;
    assign error_code   = buf_reg[0].err;
    assign last         = buf_reg[0].last;

    a_last_closes_item: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && (cnt_reg == 2'd1)) |-> last)
        else $error("final buffered result lacks last");

    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > 2'd1) |-> !last)
        else $error("last set ahead of further results");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid && (error_code != ERR_NONE)) |-> (mode_reg == M_HALT))
        else $error("error result without halt");

    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && ((mode_reg == M_HALT) || (mode_reg == M_DONE))) |=> !tok_valid)
        else $error("result after halt or Eof");

endmodule

`default_nettype wire

// ===== test/tb_basic_like_lexer.sv =====
// tb_basic_like_lexer: self-checking bench for the streaming BASIC lexer; source bytes in,
// tokens out, both channels with random idle/stall, one source per run with a random ending.
// Depends on bll_pkg and basic_like_lexer.
`timescale 1ns / 1ps

module tb_basic_like_lexer;
    import bll_pkg::*;

    localparam int LONG_ID_LEN = 12;
    localparam int WATCHDOG    = 1000;

    typedef struct {
        logic [7:0] c;
        logic       eos;
    } byte_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               src_valid = 1'b0;
    logic               src_stall;
    logic [7:0]         ch = 8'h00;
    logic               end_of_source = 1'b0;
    logic               tok_valid;
    logic               tok_stall = 1'b0;
    logic [4:0]         token_kind;
    logic [TOKEN_W-1:0] token_start;
    logic [TOKEN_W-1:0] token_length;
    logic [2:0]         error_code;
    logic               last;

    basic_like_lexer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .ch            (ch),
        .end_of_source (end_of_source),
        .tok_valid     (tok_valid),
        .tok_stall     (tok_stall),
        .token_kind    (token_kind),
        .token_start   (token_start),
        .token_length  (token_length),
        .error_code    (error_code),
        .last          (last)
    );

    always #2 clk = ~clk;

    byte_item_t src_q[$];
    res_t       token_q[$];
    res_t       step_toks[$];
    int         items_sent = 0;
    int         toks_checked = 0;
    int         mismatches = 0;
    int         src_wait = 0;
    int         stall_left = 0;
    int         idle_cycles = 0;

    string kw_names [NUM_KW] = '{"LABEL", "GOTO", "PRINT", "INPUT", "LET", "IF",
                                 "THEN", "ENDIF", "WHILE", "REPEAT", "ENDWHILE"};
    string odd_names [10] = '{"eq", "plus", "newline", "let", "LABE", "GOTOX", "IFF",
                               "ENDWHIL", "Print", "WHILE9"};
    string op_texts [11] = '{"=", "+", "-", "*", "/", "==", "!=", "<", "<=", ">", ">="};
    string alnum = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
    logic [7:0] blank_set [5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

    // lexer state as the block should hold it
    mode_t         lx_mode = M_IDLE;
    logic [15:0]   pos = '0;
    logic [15:0]   tok_begin = '0;
    logic [10:0]   kw_live = '1;
    logic [3:0]    id_len = '0;
    logic          last_nl = 1'b0;
    logic [15:0]   run_len = '0;

    function automatic logic digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic alpha_ch(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic blank_ch(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
    endfunction

    function automatic void put_tok(logic [4:0] k, logic [15:0] s, logic [15:0] l,
                                    logic [2:0] e);
        res_t r;
        r.kind   = k;
        r.start  = s;
        r.length = l;
        r.err    = e;
        r.last   = 1'b0;
        step_toks.push_back(r);
    endfunction

    function automatic void halt_on(logic [15:0] p, logic [2:0] e);
        put_tok(K_EOF, p, 16'd0, e);
        lx_mode = M_HALT;
    endfunction

    function automatic void grow();
        if (run_len != 16'hFFFF)
            run_len = run_len + 16'd1;
    endfunction

    function automatic void ident_push(logic [7:0] c);
        if (id_len < MAX_KW_LEN) begin
            for (int k = 0; k < NUM_KW; k++)
                if (id_len >= kw_names[k].len() || kw_names[k][id_len] != c)
                    kw_live[k] = 1'b0;
            id_len = id_len + 4'd1;
        end
        else begin
            kw_live = '0;
            id_len  = 4'(MAX_KW_LEN + 1);
        end
        grow();
    endfunction

    function automatic void close_pending();
        logic [4:0] kind;
        case (lx_mode)
            M_INT, M_FRAC: put_tok(K_NUM, tok_begin, run_len, ERR_NONE);
            M_IDENT:
            begin
                kind = K_IDENT;
                for (int k = 0; k < NUM_KW; k++)
                    if (kw_live[k] && kw_names[k].len() == id_len)
                        kind = K_KW0 + 5'(k);
                put_tok(kind, tok_begin, run_len, ERR_NONE);
            end
            M_EQ: put_tok(K_EQ, tok_begin, 16'd1, ERR_NONE);
            M_GT: put_tok(K_GT, tok_begin, 16'd1, ERR_NONE);
            M_LT: put_tok(K_LT, tok_begin, 16'd1, ERR_NONE);
            default: ;
        endcase
        lx_mode = M_IDLE;
    endfunction

    function automatic void start_token(logic [7:0] c, logic [15:0] p);
        lx_mode   = M_IDLE;
        tok_begin = p;
        run_len   = 16'd1;
        if (blank_ch(c))
            return;
        if (digit_ch(c))
        begin
            lx_mode = M_INT;
            return;
        end
        if (alpha_ch(c))
        begin
            lx_mode = M_IDENT;
            kw_live = '1;
            id_len  = '0;
            run_len = '0;
            ident_push(c);
            return;
        end
        case (c)
            CH_HASH:  lx_mode = M_COMMENT;
            CH_PLUS:  put_tok(K_PLUS, p, 16'd1, ERR_NONE);
            CH_MINUS: put_tok(K_MINUS, p, 16'd1, ERR_NONE);
            CH_STAR:  put_tok(K_STAR, p, 16'd1, ERR_NONE);
            CH_SLASH: put_tok(K_SLASH, p, 16'd1, ERR_NONE);
            CH_EQ:    lx_mode = M_EQ;
            CH_GT:    lx_mode = M_GT;
            CH_LT:    lx_mode = M_LT;
            CH_BANG:  lx_mode = M_BANG;
            CH_QUOTE:
            begin
                lx_mode   = M_STR;
                tok_begin = p + 16'd1;
                run_len   = '0;
            end
            CH_NL:    put_tok(K_NL, p, 16'd1, ERR_NONE);
            default:  halt_on(p, ERR_UNKNOWN);
        endcase
    endfunction

    function automatic void lex_byte(logic [7:0] c);
        logic [15:0] p;
        p = pos;
        case (lx_mode)
            M_INT:
                if (digit_ch(c))
                    grow();
                else if (c == CH_DOT)
                begin
                    grow();
                    lx_mode = M_DOT;
                end
                else
                begin
                    close_pending();
                    start_token(c, p);
                end
            M_DOT:
                if (digit_ch(c))
                begin
                    grow();
                    lx_mode = M_FRAC;
                end
                else
                    halt_on(p, ERR_NUMBER);
            M_FRAC, M_IDENT:
                if (digit_ch(c) || (lx_mode == M_IDENT && alpha_ch(c)))
                begin
                    if (lx_mode == M_IDENT)
                        ident_push(c);
                    else
                        grow();
                end
                else
                begin
                    close_pending();
                    start_token(c, p);
                end
            M_STR:
                if (c == CH_QUOTE)
                begin
                    put_tok(K_STR, tok_begin, run_len, ERR_NONE);
                    lx_mode = M_IDLE;
                end
                else if (c == CH_CR || c == CH_NL || c == CH_TAB || c == CH_BSLASH
                         || c == CH_PCT)
                    halt_on(p, ERR_STR_CHAR);
                else
                    grow();
            M_EQ, M_GT, M_LT:
                if (c == CH_EQ)
                begin
                    put_tok(lx_mode == M_EQ ? K_EQEQ : (lx_mode == M_GT ? K_GTEQ : K_LTEQ),
                            tok_begin, 16'd2, ERR_NONE);
                    lx_mode = M_IDLE;
                end
                else
                begin
                    close_pending();
                    start_token(c, p);
                end
            M_BANG:
                if (c == CH_EQ)
                begin
                    put_tok(K_NOTEQ, tok_begin, 16'd2, ERR_NONE);
                    lx_mode = M_IDLE;
                end
                else
                    halt_on(p, ERR_BANG);
            M_COMMENT:
                if (c == CH_NL)
                    start_token(c, p);
            default: start_token(c, p);
        endcase
        pos     = pos + 16'd1;
        last_nl = (c == CH_NL);
    endfunction

    function automatic void lex_step(logic [7:0] c, logic eos);
        if (lx_mode == M_HALT || lx_mode == M_DONE)
            return;
        step_toks.delete();
        if (eos || c == CH_NUL)
        begin
            if (!last_nl)
                lex_byte(CH_NL);
            if (lx_mode != M_HALT)
            begin
                put_tok(K_EOF, pos, 16'd0, ERR_NONE);
                lx_mode = M_DONE;
            end
        end
        else
            lex_byte(c);
        if (step_toks.size() > 0)
            step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i])
            token_q.push_back(step_toks[i]);
    endfunction

    task automatic put_byte(logic [7:0] c);
        byte_item_t it;
        it.c   = c;
        it.eos = 1'b0;
        src_q.push_back(it);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    task automatic put_token();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0, 1: put_text(kw_names[$urandom_range(0, NUM_KW - 1)]);
            2:    put_text(odd_names[$urandom_range(0, 9)]);
            3:
            begin
                put_byte(alnum[$urandom_range(0, 51)]);
                repeat ($urandom_range(0, 9))
                    put_byte(alnum[$urandom_range(0, 61)]);
            end
            4:
            begin
                // keep a number from gluing onto a preceding word or fraction
                put_byte(CH_SPACE);
                repeat ($urandom_range(1, 5))
                    put_byte(alnum[$urandom_range(52, 61)]);
                if ($urandom_range(0, 1))
                begin
                    put_byte(CH_DOT);
                    repeat ($urandom_range(1, 3))
                        put_byte(alnum[$urandom_range(52, 61)]);
                end
            end
            5:
            begin
                put_byte(CH_QUOTE);
                repeat ($urandom_range(0, 6))
                begin
                    do
                        c = 8'($urandom_range(1, 255));
                    while (c == CH_QUOTE || c == CH_CR || c == CH_NL || c == CH_TAB
                           || c == CH_BSLASH || c == CH_PCT);
                    put_byte(c);
                end
                put_byte(CH_QUOTE);
            end
            6:
            begin
                put_byte(CH_HASH);
                repeat ($urandom_range(0, 6))
                begin
                    do
                        c = 8'($urandom_range(1, 255));
                    while (c == CH_NL);
                    put_byte(c);
                end
                put_byte(CH_NL);
            end
            7, 8: put_text(op_texts[$urandom_range(0, 10)]);
            default:
            begin
                if ($urandom_range(0, 1))
                    put_byte(CH_CR);
                put_byte(CH_NL);
            end
        endcase
        case ($urandom_range(0, 3))
            2: put_byte(blank_set[$urandom_range(0, 4)]);
            3: put_byte(CH_NL);
            default: ;
        endcase
    endtask

    task automatic flag_bad(string msg);
        if (mismatches < 10)
            $display("%s", msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : src_drive
        int gap;
        byte_item_t nxt;
        if (!rst_n)
        begin
            src_valid     <= 1'b0;
            ch            <= 8'h00;
            end_of_source <= 1'b0;
            src_wait      <= 0;
        end
        else if (!src_valid || !src_stall)
        begin
            gap = src_wait;
            if (src_valid)
            begin
                lex_step(ch, end_of_source);
                items_sent++;
                gap = ((items_sent / 32) % 4 == 1) ? 0 : int'($urandom_range(0, 4));
            end
            if (gap == 0 && src_q.size() != 0)
            begin
                nxt = src_q.pop_front();
                src_valid     <= 1'b1;
                ch            <= nxt.c;
                end_of_source <= nxt.eos;
                src_wait      <= 0;
            end
            else
            begin
                src_valid <= 1'b0;
                src_wait  <= (gap > 0) ? gap - 1 : 0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : tok_check
        res_t got;
        res_t want;
        int   k;
        if (!rst_n)
        begin
            tok_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (tok_valid && !tok_stall)
        begin
            got = {token_kind, token_start, token_length, error_code, last};
            toks_checked++;
            if (token_q.size() == 0)
                flag_bad($sformatf("unexpected token: kind %0d start %0d len %0d err %0d last %0d",
                                   got.kind, got.start, got.length, got.err, got.last));
            else
            begin
                want = token_q.pop_front();
                if (got !== want)
                    flag_bad($sformatf({"token %0d: exp kind %0d start %0d len %0d err %0d ",
                                        "last %0d, got kind %0d start %0d len %0d err %0d last %0d"},
                                       toks_checked, want.kind, want.start, want.length,
                                       want.err, want.last, got.kind, got.start, got.length,
                                       got.err, got.last));
            end
            k = ((toks_checked / 40) % 4 == 3) ? 0 : int'($urandom_range(0, 4));
            tok_stall  <= (k != 0);
            stall_left <= k;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            tok_stall  <= (stall_left > 1);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && !src_stall) || (tok_valid && !tok_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("timeout: no handshake for %0d cycles", WATCHDOG);
                $display("tb_basic_like_lexer failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        byte_item_t it;
        logic [7:0] c;
        string      ending;
        // directed opener: long keyword, lowercase name, lookahead op, fraction,
        // string with a high byte, comment
        put_text("ENDWHILE eq<3.25 \"q");
        put_byte(8'hFF);
        put_text("\"#x");
        put_byte(CH_NL);
        while (src_q.size() < 150)
            put_token();
        // one identifier that runs past the longest keyword
        put_text("ENDWHILE");
        repeat (LONG_ID_LEN - 8)
            put_byte(alnum[$urandom_range(0, 61)]);
        put_byte(CH_SPACE);
        while (src_q.size() < 300)
            put_token();
        put_byte(CH_SPACE);
        case ($urandom_range(0, 7))
            0:
            begin
                ending = "end flag after newline";
                put_byte(CH_NL);
            end
            1:
            begin
                ending = "end flag with pending token";
                put_text("x1");
            end
            2:
            begin
                ending = "zero byte";
                put_text("a>");
            end
            3:
            begin
                ending = "bad number";
                put_text($urandom_range(0, 1) ? "12." : "5.x");
            end
            4:
            begin
                ending = "lone bang";
                put_text($urandom_range(0, 1) ? "!" : "!a");
            end
            5:
            begin
                ending = "bad string char";
                put_text("\"ab");
                case ($urandom_range(0, 5))
                    0: put_byte(CH_CR);
                    1: put_byte(CH_NL);
                    2: put_byte(CH_TAB);
                    3: put_byte(CH_BSLASH);
                    4: put_byte(CH_PCT);
                    default: ;
                endcase
            end
            default:
            begin
                ending = "unknown char";
                do
                    c = 8'($urandom_range(1, 255));
                while (digit_ch(c) || alpha_ch(c) || blank_ch(c) || c == CH_NL
                       || c == CH_HASH || c == CH_PLUS || c == CH_MINUS || c == CH_STAR
                       || c == CH_SLASH || c == CH_EQ || c == CH_GT || c == CH_LT
                       || c == CH_BANG || c == CH_QUOTE);
                put_byte(c);
            end
        endcase
        it.c   = (ending == "zero byte") ? CH_NUL : 8'($urandom_range(0, 255));
        it.eos = (ending != "zero byte");
        src_q.push_back(it);
        // trailing items must be swallowed without output
        repeat (5)
        begin
            it.c   = 8'($urandom_range(0, 255));
            it.eos = 1'($urandom_range(0, 1));
            src_q.push_back(it);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        while (src_q.size() != 0 || src_valid || token_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run: %0d source bytes incl. a %0d-char identifier, %0d tokens compared",
                 items_sent, LONG_ID_LEN, toks_checked);
        $display("source ended by %s, %0d mismatches", ending, mismatches);
        if (mismatches == 0 && token_q.size() == 0)
            $display("tb_basic_like_lexer passed");
        else
            $display("tb_basic_like_lexer failed");
        $finish;
    end

endmodule
